// File: rtl/efjv_pkg.sv
// ----------------------------------------------------------------------------
// efjv_pkg
// Shared types and constants for the encoder frame jump validator.
// ----------------------------------------------------------------------------
package efjv_pkg;

    // Field widths fixed by the register map and the result layout
    localparam int STEP_W   = 19;
    localparam int AGE_W    = 32;
    localparam int CNT_W    = 32;
    localparam int KIND_W   = 3;
    localparam int FRAME_W  = 24;
    localparam int STATUS_W = 2;

    // Default build values
    localparam int DEFAULT_POSITION_BITS = 19;
    localparam int DEFAULT_FRAME_SHIFT   = 4;

    // Register reset values
    localparam logic [STEP_W-1:0] MAX_STEP_RESET = STEP_W'(2913);
    localparam logic [AGE_W-1:0]  MAX_AGE_RESET  = AGE_W'(10);

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MAX_STEP = 1'b0;   // byte address 0
    localparam logic REG_MAX_AGE  = 1'b1;   // byte address 4

    // Event kinds on the input tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_FRAME       = 3'd0,
        KIND_LINK_ERROR  = 3'd1,
        KIND_START_ERROR = 3'd2,
        KIND_TICK        = 3'd3,
        KIND_REARM       = 3'd4
    } t_kind;

    // Per-item sample status on the output tuser
    typedef enum logic [STATUS_W-1:0] {
        STATUS_NONE     = 2'd0,
        STATUS_ACCEPTED = 2'd1,
        STATUS_REJECTED = 2'd2
    } t_status;

endpackage

// File: rtl/efjv_step_chk.sv
// ----------------------------------------------------------------------------
// efjv_step_chk
// Wrapped position distance and step limit compare.
// ----------------------------------------------------------------------------
module efjv_step_chk #(
    parameter int POSITION_BITS = efjv_pkg::DEFAULT_POSITION_BITS
) (
    input  logic [POSITION_BITS-1:0]   i_pos,
    input  logic [POSITION_BITS-1:0]   i_held,
    input  logic [efjv_pkg::STEP_W-1:0] i_max_step,
    output logic                       o_step_ok
);

    localparam int CMP_W = (POSITION_BITS > efjv_pkg::STEP_W) ?
                           POSITION_BITS : efjv_pkg::STEP_W;
    localparam logic [POSITION_BITS-1:0] HALF_TURN = {1'b1, {(POSITION_BITS-1){1'b0}}};

    logic [POSITION_BITS-1:0] w_diff;
    logic [POSITION_BITS-1:0] w_mag;

    // Distance modulo one turn; the shorter way round gives the magnitude.
    // Exactly half a turn has the same magnitude either way.
    assign w_diff = i_pos - i_held;
    assign w_mag  = (w_diff <= HALF_TURN) ? w_diff : (POSITION_BITS'(0) - w_diff);

    assign o_step_ok = CMP_W'(w_mag) < CMP_W'(i_max_step);

endmodule

// File: rtl/encoder_frame_jump_validator_core.sv
// ----------------------------------------------------------------------------
// encoder_frame_jump_validator_core
// Absolute encoder position filter: rejects frames that jump too far from the
// last verified position, counts events and tracks sample age.
// ----------------------------------------------------------------------------
//
//  Channel    Dir  Handshake                 Payload
//  s_axis     in   tvalid/tready             tdata: frame_bits; tuser: kind
//  m_axis     out  tvalid/tready             tdata: result fields; tuser: status
//  apb        in   psel/penable/pready       step limit, age limit
//
//  One item per cycle sustained while the result stream takes items. An item
//  is held in the input register and then evaluated and written to the result
//  register. The state update is a single compare and counter increment per
//  item. Synchronous reset clears state and counters and restores register
//  defaults. A stalled output holds the result and backs up into the input
//  register; s_axis_tready drops only when both stages are full.
//
module encoder_frame_jump_validator_core #(
    parameter int POSITION_BITS = efjv_pkg::DEFAULT_POSITION_BITS,
    parameter int FRAME_SHIFT   = efjv_pkg::DEFAULT_FRAME_SHIFT,
    localparam int OUT_BITS     = POSITION_BITS + efjv_pkg::AGE_W + 1 + 4 * efjv_pkg::CNT_W,
    localparam int OUT_DATA_W   = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [efjv_pkg::FRAME_W-1:0]          s_axis_tdata,  // frame_bits
    input  logic [efjv_pkg::KIND_W-1:0]           s_axis_tuser,  // kind
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // verified_angle, frame_age_ms, fresh, valid_count, rejected_count,
    // link_error_count, start_error_count, zero fill
    output logic [OUT_DATA_W-1:0]                 m_axis_tdata,
    output logic [efjv_pkg::STATUS_W-1:0]         m_axis_tuser,  // sample_status
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [efjv_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [efjv_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [efjv_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    localparam int CNT_W = efjv_pkg::CNT_W;
    localparam int AGE_W = efjv_pkg::AGE_W;

    // Configuration registers
    logic [efjv_pkg::STEP_W-1:0] r_max_step;
    logic [AGE_W-1:0]            r_max_age;

    // Input stage
    logic                        r_in_valid;
    efjv_pkg::t_kind             r_in_kind;
    logic [efjv_pkg::FRAME_W-1:0] r_in_frame;

    // Tracking state
    logic [POSITION_BITS-1:0]    r_held,       n_held;
    logic                        r_awaiting,   n_awaiting;
    logic                        r_have,       n_have;
    logic [AGE_W-1:0]            r_age,        n_age;
    logic [CNT_W-1:0]            r_acc_total,  n_acc_total;
    logic [CNT_W-1:0]            r_rej_total,  n_rej_total;
    logic [CNT_W-1:0]            r_link_total, n_link_total;
    logic [CNT_W-1:0]            r_start_total, n_start_total;
    efjv_pkg::t_status           n_status;

    // Result register
    logic                        r_res_valid;
    logic [OUT_DATA_W-1:0]       r_res_data;
    efjv_pkg::t_status           r_res_status;

    logic                        w_advance;
    logic                        w_fire;
    logic                        w_cfg_wr;
    logic [efjv_pkg::FRAME_W-1:0] w_shifted;
    logic [POSITION_BITS-1:0]    w_pos;
    logic                        w_step_ok;
    logic [AGE_W-1:0]            w_age_out;
    logic                        w_fresh;

    // Handshakes
    assign w_advance     = !r_res_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_res_valid;
    assign m_axis_tdata  = r_res_data;
    assign m_axis_tuser  = r_res_status;

    // APB: always ready, index from the word address bit
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            efjv_pkg::REG_MAX_STEP: prdata = efjv_pkg::APB_DATA_W'(r_max_step);
            efjv_pkg::REG_MAX_AGE:  prdata = r_max_age;
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_step <= efjv_pkg::MAX_STEP_RESET;
            r_max_age  <= efjv_pkg::MAX_AGE_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                efjv_pkg::REG_MAX_STEP: r_max_step <= pwdata[efjv_pkg::STEP_W-1:0];
                efjv_pkg::REG_MAX_AGE:  r_max_age  <= pwdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind  <= efjv_pkg::t_kind'(s_axis_tuser);
            r_in_frame <= s_axis_tdata;
        end
    end

    function automatic logic [efjv_pkg::FRAME_W-1:0] s_axis_frame_shift(
        input logic [efjv_pkg::FRAME_W-1:0] frame
    );
        s_axis_frame_shift = frame >> FRAME_SHIFT;
    endfunction

    // Position extract and step check
    assign w_shifted = s_axis_frame_shift(r_in_frame);
    assign w_pos     = w_shifted[POSITION_BITS-1:0];

    efjv_step_chk #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step_chk (
        .i_pos      (w_pos),
        .i_held     (r_held),
        .i_max_step (r_max_step),
        .o_step_ok  (w_step_ok)
    );

    // Next state for the item in the input register
    always_comb begin
        n_held        = r_held;
        n_awaiting    = r_awaiting;
        n_have        = r_have;
        n_age         = r_age;
        n_acc_total   = r_acc_total;
        n_rej_total   = r_rej_total;
        n_link_total  = r_link_total;
        n_start_total = r_start_total;
        n_status      = efjv_pkg::STATUS_NONE;
        case (r_in_kind)
            efjv_pkg::KIND_FRAME: begin
                if (r_awaiting || w_step_ok) begin
                    n_held      = w_pos;
                    n_awaiting  = 1'b0;
                    n_have      = 1'b1;
                    n_age       = '0;
                    n_acc_total = r_acc_total + CNT_W'(1);
                    n_status    = efjv_pkg::STATUS_ACCEPTED;
                end else begin
                    n_rej_total = r_rej_total + CNT_W'(1);
                    n_status    = efjv_pkg::STATUS_REJECTED;
                end
            end
            efjv_pkg::KIND_LINK_ERROR: begin
                n_link_total = r_link_total + CNT_W'(1);
            end
            efjv_pkg::KIND_START_ERROR: begin
                n_start_total = r_start_total + CNT_W'(1);
            end
            efjv_pkg::KIND_TICK: begin
                // saturating age
                if (r_age != '1) begin
                    n_age = r_age + AGE_W'(1);
                end
            end
            efjv_pkg::KIND_REARM: begin
                n_awaiting = 1'b1;
                n_have     = 1'b0;
            end
            default: ;
        endcase
    end

    // Age as reported: all ones with no sample since rearm
    assign w_age_out = n_have ? n_age : '1;
    assign w_fresh   = w_age_out <= r_max_age;

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held        <= '0;
            r_awaiting    <= 1'b1;
            r_have        <= 1'b0;
            r_age         <= '0;
            r_acc_total   <= '0;
            r_rej_total   <= '0;
            r_link_total  <= '0;
            r_start_total <= '0;
        end else if (w_fire) begin
            r_held        <= n_held;
            r_awaiting    <= n_awaiting;
            r_have        <= n_have;
            r_age         <= n_age;
            r_acc_total   <= n_acc_total;
            r_rej_total   <= n_rej_total;
            r_link_total  <= n_link_total;
            r_start_total <= n_start_total;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_advance) begin
            r_res_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res_data   <= OUT_DATA_W'({n_start_total, n_link_total, n_rej_total,
                                         n_acc_total, w_fresh, w_age_out, n_held});
            r_res_status <= n_status;
        end
    end

`ifndef SYNTHESIS
    // An accepted frame always reports zero age, which is always fresh
    a_accept_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_status == efjv_pkg::STATUS_ACCEPTED)
            |=> (r_res_data[POSITION_BITS +: AGE_W] == '0)
                && r_res_data[POSITION_BITS + AGE_W])
        else $error("accepted frame did not report fresh zero age");

    // Accepted total moves only on an accepted frame
    a_acc_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_acc_total != $past(r_acc_total))
            |-> $past(w_fire && n_status == efjv_pkg::STATUS_ACCEPTED))
        else $error("accepted total changed without an accepted frame");

    // Input backs up only when both stages hold items and the output stalls
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_res_valid && !m_axis_tready))
        else $error("input stalled without a full pipeline");
`endif

endmodule

// File: tb/sv/encoder_frame_jump_validator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_frame_jump_validator_core_test
// Self-checking bench for the encoder jump filter. A short event table covers
// the first frame, wrap across zero, the step boundary, the error counters,
// the freshness limit, rearm and unused kinds. Random events then run under
// several limit settings and idle patterns. Every result item is checked
// field by field against the table or a local model of the filter.
// ----------------------------------------------------------------------------
module encoder_frame_jump_validator_core_test;

    localparam int FRAME_W    = efjv_pkg::FRAME_W;
    localparam int KIND_W     = efjv_pkg::KIND_W;
    localparam int STATUS_W   = efjv_pkg::STATUS_W;
    localparam int AGE_W      = efjv_pkg::AGE_W;
    localparam int CNT_W      = efjv_pkg::CNT_W;
    localparam int STEP_W     = efjv_pkg::STEP_W;
    localparam int APB_ADDR_W = efjv_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = efjv_pkg::APB_DATA_W;
    localparam int POS_W      = efjv_pkg::DEFAULT_POSITION_BITS;
    localparam int SHIFT      = efjv_pkg::DEFAULT_FRAME_SHIFT;
    localparam int TOP_W      = FRAME_W - POS_W - SHIFT;
    localparam int FULL_TURN  = 1 << POS_W;
    localparam int HALF_TURN  = 1 << (POS_W - 1);
    localparam int OUT_W      = ((POS_W + AGE_W + 1 + 4 * CNT_W + 7) / 8) * 8;
    localparam int AGE_LSB    = POS_W;
    localparam int FRESH_BIT  = AGE_LSB + AGE_W;
    localparam int VALID_LSB  = FRESH_BIT + 1;
    localparam int REJ_LSB    = VALID_LSB + CNT_W;
    localparam int LINK_LSB   = REJ_LSB + CNT_W;
    localparam int START_LSB  = LINK_LSB + CNT_W;
    localparam int JUNK_W     = APB_DATA_W - STEP_W;
    localparam int N_PHASES   = 7;
    localparam int PHASE_ITEMS = 120;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS = 10;

    // kinds the block ignores
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam logic [AGE_W-1:0]  NO_SAMPLE_AGE = '1;

    typedef struct {
        logic [POS_W-1:0]    angle;
        logic [STATUS_W-1:0] status;
        logic [AGE_W-1:0]    age;
        logic                fresh;
        logic [CNT_W-1:0]    accepted;
        logic [CNT_W-1:0]    rejected;
        logic [CNT_W-1:0]    link_errors;
        logic [CNT_W-1:0]    start_errors;
    } t_reading;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [FRAME_W-1:0] frame;
        bit                 typed;
        t_reading           want;
    } t_event_row;

    // bench signals
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [FRAME_W-1:0]    s_axis_tdata = '0;   // frame_bits
    logic [KIND_W-1:0]     s_axis_tuser = '0;   // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // verified_angle, frame_age_ms, fresh, valid_count, rejected_count,
    // link_error_count, start_error_count, zero fill
    logic [OUT_W-1:0]      m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;        // sample_status
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // filter model state and limits
    logic [POS_W-1:0] held_pos = '0;
    logic             awaiting_first = 1'b1;
    logic             have_sample = 1'b0;
    logic [AGE_W-1:0] age_count = '0;
    logic [CNT_W-1:0] accepted_total = '0;
    logic [CNT_W-1:0] rejected_total = '0;
    logic [CNT_W-1:0] link_error_total = '0;
    logic [CNT_W-1:0] start_error_total = '0;
    logic [STEP_W-1:0] step_limit = efjv_pkg::MAX_STEP_RESET;
    logic [AGE_W-1:0]  age_limit = efjv_pkg::MAX_AGE_RESET;

    t_reading   pending_readings[$];
    t_event_row directed_rows[$];
    t_reading   no_reading;
    int         mismatches = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    logic [31:0] step_plan [N_PHASES];
    logic [31:0] age_plan [N_PHASES];

    encoder_frame_jump_validator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("encoder_frame_jump_validator_core_test failed");
        $finish;
    end

    // |wrapped distance| strictly below the step limit
    function automatic bit within_step(input logic [POS_W-1:0] pos);
        int d;
        d = int'(pos) - int'(held_pos);
        if (d > HALF_TURN) d = d - FULL_TURN;
        if (d < -HALF_TURN) d = d + FULL_TURN;
        if (d < 0) d = -d;
        return d < int'(step_limit);
    endfunction

    // advance the filter model by one event and return its result item
    function automatic t_reading apply_event(input logic [KIND_W-1:0] kind,
                                             input logic [FRAME_W-1:0] frame);
        t_reading r;
        logic [POS_W-1:0] pos;
        r.status = efjv_pkg::STATUS_NONE;
        pos = POS_W'(frame >> SHIFT);
        case (kind)
            efjv_pkg::KIND_FRAME: begin
                if (awaiting_first || within_step(pos)) begin
                    held_pos       = pos;
                    awaiting_first = 1'b0;
                    have_sample    = 1'b1;
                    age_count      = '0;
                    accepted_total = accepted_total + 1'b1;
                    r.status       = efjv_pkg::STATUS_ACCEPTED;
                end else begin
                    rejected_total = rejected_total + 1'b1;
                    r.status       = efjv_pkg::STATUS_REJECTED;
                end
            end
            efjv_pkg::KIND_LINK_ERROR: link_error_total = link_error_total + 1'b1;
            efjv_pkg::KIND_START_ERROR: start_error_total = start_error_total + 1'b1;
            efjv_pkg::KIND_TICK: begin
                // saturating age
                if (age_count != '1) age_count = age_count + 1'b1;
            end
            efjv_pkg::KIND_REARM: begin
                awaiting_first = 1'b1;
                have_sample    = 1'b0;
            end
            default: ;
        endcase
        r.angle        = held_pos;
        r.age          = have_sample ? age_count : NO_SAMPLE_AGE;
        r.fresh        = (r.age <= age_limit);
        r.accepted     = accepted_total;
        r.rejected     = rejected_total;
        r.link_errors  = link_error_total;
        r.start_errors = start_error_total;
        return r;
    endfunction

    function automatic t_reading reading_of(input int angle, input int status,
                                            input int age, input int fresh,
                                            input int acc, input int rej,
                                            input int link, input int start);
        t_reading r;
        r.angle        = POS_W'(angle);
        r.status       = STATUS_W'(status);
        r.age          = AGE_W'(age);
        r.fresh        = 1'(fresh);
        r.accepted     = CNT_W'(acc);
        r.rejected     = CNT_W'(rej);
        r.link_errors  = CNT_W'(link);
        r.start_errors = CNT_W'(start);
        return r;
    endfunction

    function automatic logic [FRAME_W-1:0] frame_of(input int pos);
        return FRAME_W'(pos << SHIFT);
    endfunction

    // random event kind, frames most often
    function automatic logic [KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 48) return efjv_pkg::KIND_FRAME;
        else if (r < 78) return efjv_pkg::KIND_TICK;
        else if (r < 84) return efjv_pkg::KIND_LINK_ERROR;
        else if (r < 90) return efjv_pkg::KIND_START_ERROR;
        else if (r < 95) return efjv_pkg::KIND_REARM;
        else return KIND_SPARE_LO + KIND_W'($urandom_range(0, 2));
    endfunction

    // frames mostly land near the held position and the step boundary
    function automatic logic [FRAME_W-1:0] pick_frame();
        int offset;
        int span;
        logic [POS_W-1:0] pos;
        span = 2 * int'(step_limit) + 4;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: offset = int'($urandom_range(0, 2 * span)) - span;
            4: offset = int'(step_limit);
            5: offset = int'(step_limit) - 1;
            6: offset = HALF_TURN;
            7: offset = HALF_TURN + 1;
            default: return FRAME_W'($urandom());
        endcase
        if ($urandom_range(0, 1)) offset = -offset;
        pos = held_pos + POS_W'(offset);
        return {TOP_W'($urandom()), pos, SHIFT'($urandom())};
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %0d at %0t: %s expected %0h got %0h",
                     mismatches, $realtime, what, want, got);
    endtask

    task automatic check_reading(input logic [OUT_W-1:0] data,
                                 input logic [STATUS_W-1:0] status);
        t_reading want;
        if (pending_readings.size() == 0) begin
            note_mismatch("result item with nothing pending", '0, '0);
            return;
        end
        want = pending_readings.pop_front();
        if (data[POS_W-1:0] !== want.angle)
            note_mismatch("verified_angle", want.angle, data[POS_W-1:0]);
        if (status !== want.status)
            note_mismatch("sample_status", want.status, status);
        if (data[AGE_LSB +: AGE_W] !== want.age)
            note_mismatch("frame_age_ms", want.age, data[AGE_LSB +: AGE_W]);
        if (data[FRESH_BIT] !== want.fresh)
            note_mismatch("fresh", want.fresh, data[FRESH_BIT]);
        if (data[VALID_LSB +: CNT_W] !== want.accepted)
            note_mismatch("valid_count", want.accepted, data[VALID_LSB +: CNT_W]);
        if (data[REJ_LSB +: CNT_W] !== want.rejected)
            note_mismatch("rejected_count", want.rejected, data[REJ_LSB +: CNT_W]);
        if (data[LINK_LSB +: CNT_W] !== want.link_errors)
            note_mismatch("link_error_count", want.link_errors, data[LINK_LSB +: CNT_W]);
        if (data[START_LSB +: CNT_W] !== want.start_errors)
            note_mismatch("start_error_count", want.start_errors,
                          data[START_LSB +: CNT_W]);
    endtask

    // result side: check accepted items, random back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_reading(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // present one item, returns at the edge where it is taken
    task automatic send_event(input logic [KIND_W-1:0] kind,
                              input logic [FRAME_W-1:0] frame);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= frame;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // send, then queue the typed or the modeled result
    task automatic issue_event(input logic [KIND_W-1:0] kind,
                               input logic [FRAME_W-1:0] frame,
                               input bit typed, input t_reading want);
        t_reading modeled;
        send_event(kind, frame);
        modeled = apply_event(kind, frame);
        pending_readings.push_back(typed ? want : modeled);
    endtask

    // hold off until every result item is back and the pipe is quiet
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == efjv_pkg::REG_MAX_STEP) step_limit = value[STEP_W-1:0];
        else age_limit = value;
    endtask

    // both limits, junk in the unused step bits
    task automatic load_limits(input logic [31:0] step_val, input logic [31:0] age_val);
        write_reg(efjv_pkg::REG_MAX_STEP, {JUNK_W'($urandom()), step_val[STEP_W-1:0]});
        write_reg(efjv_pkg::REG_MAX_AGE, age_val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic add_row(input logic [KIND_W-1:0] kind, input logic [FRAME_W-1:0] frame,
                           input bit typed, input t_reading want);
        t_event_row row;
        row.kind  = kind;
        row.frame = frame;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // event table, default limits (step 2913, age 10)
    task automatic build_rows();
        add_row(efjv_pkg::KIND_TICK, '0, 1'b1,
                reading_of(0, efjv_pkg::STATUS_NONE, NO_SAMPLE_AGE, 0, 0, 0, 0, 0));
        add_row(KIND_SPARE_HI, 24'hFFFFFF, 1'b1,
                reading_of(0, efjv_pkg::STATUS_NONE, NO_SAMPLE_AGE, 0, 0, 0, 0, 0));
        // first frame taken whatever its distance
        add_row(efjv_pkg::KIND_FRAME, 24'hFFFFFF, 1'b1,
                reading_of(19'h7FFFF, efjv_pkg::STATUS_ACCEPTED, 0, 1, 1, 0, 0, 0));
        // wraps across zero: distance one
        add_row(efjv_pkg::KIND_FRAME, 24'h000000, 1'b1,
                reading_of(0, efjv_pkg::STATUS_ACCEPTED, 0, 1, 2, 0, 0, 0));
        add_row(efjv_pkg::KIND_FRAME, frame_of(2912), 1'b1,
                reading_of(2912, efjv_pkg::STATUS_ACCEPTED, 0, 1, 3, 0, 0, 0));
        // distance equal to the limit is rejected
        add_row(efjv_pkg::KIND_FRAME, frame_of(5825), 1'b1,
                reading_of(2912, efjv_pkg::STATUS_REJECTED, 0, 1, 3, 1, 0, 0));
        add_row(efjv_pkg::KIND_LINK_ERROR, 24'hFFFFFF, 1'b1,
                reading_of(2912, efjv_pkg::STATUS_NONE, 0, 1, 3, 1, 1, 0));
        add_row(efjv_pkg::KIND_START_ERROR, '0, 1'b1,
                reading_of(2912, efjv_pkg::STATUS_NONE, 0, 1, 3, 1, 1, 1));
        for (int n = 0; n < 9; n++)
            add_row(efjv_pkg::KIND_TICK, FRAME_W'($urandom()), 1'b0, no_reading);
        // age at the limit is fresh, one past is stale
        add_row(efjv_pkg::KIND_TICK, '0, 1'b1,
                reading_of(2912, efjv_pkg::STATUS_NONE, 10, 1, 3, 1, 1, 1));
        add_row(efjv_pkg::KIND_TICK, '0, 1'b1,
                reading_of(2912, efjv_pkg::STATUS_NONE, 11, 0, 3, 1, 1, 1));
        // top bit and low nibble fall outside the position
        add_row(efjv_pkg::KIND_FRAME, 24'h800000 | frame_of(2000) | 24'hF, 1'b1,
                reading_of(2000, efjv_pkg::STATUS_ACCEPTED, 0, 1, 4, 1, 1, 1));
        add_row(efjv_pkg::KIND_REARM, '0, 1'b1,
                reading_of(2000, efjv_pkg::STATUS_NONE, NO_SAMPLE_AGE, 0, 4, 1, 1, 1));
        add_row(efjv_pkg::KIND_TICK, '0, 1'b0, no_reading);
        add_row(efjv_pkg::KIND_FRAME, frame_of(300000), 1'b1,
                reading_of(300000, efjv_pkg::STATUS_ACCEPTED, 0, 1, 5, 1, 1, 1));
        // exactly half a turn away
        add_row(efjv_pkg::KIND_FRAME, frame_of(37856), 1'b1,
                reading_of(300000, efjv_pkg::STATUS_REJECTED, 0, 1, 5, 2, 1, 1));
        add_row(efjv_pkg::KIND_FRAME, frame_of(301000), 1'b0, no_reading);
    endtask

    // stimulus
    initial begin
        no_reading = reading_of(0, efjv_pkg::STATUS_NONE, 0, 0, 0, 0, 0, 0);
        step_plan = '{32'd2913, 32'd262144, 32'd262145, 32'd0, 32'd524287, 32'd0, 32'd1};
        age_plan  = '{32'd10, 32'd0, 32'hFFFFFFFF, 32'd3, 32'd1, 32'd0, 32'hFFFFFFFE};
        step_plan[5] = $urandom_range(1, 5000);
        age_plan[5]  = $urandom_range(0, 20);
        send_idle_pct = 31;
        recv_idle_pct = 48;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_rows();
        foreach (directed_rows[i])
            issue_event(directed_rows[i].kind, directed_rows[i].frame,
                        directed_rows[i].typed, directed_rows[i].want);
        drain();

        // random events under each limit setting
        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 3) begin
                send_idle_pct = 48;
                recv_idle_pct = 31;
            end else if (p == 5) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_limits(step_plan[p], age_plan[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                issue_event(pick_kind(), pick_frame(), 1'b0, no_reading);
            drain();
        end

        if (mismatches == 0) begin
            $display("encoder_frame_jump_validator_core_test passed");
        end else begin
            $display("encoder_frame_jump_validator_core_test failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/efjv_pkg.sv
rtl/efjv_step_chk.sv
rtl/encoder_frame_jump_validator_core.sv
tb/sv/encoder_frame_jump_validator_core_test.sv
